// ----- rtl/core/pebs_pkg.sv -----
package pebs_pkg;

    localparam int DataW    = 32;
    localparam int ProdW    = 50;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    localparam logic [CfgIdxW-1:0] CFG_TIME_STEP  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GRAVITY    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_FIELD_W    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FIELD_H    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_FRICTION   = 3'd4;

    localparam logic [15:0] TimeStepRst = 16'd1092;
    localparam logic [23:0] GravityRst  = 24'd642689;
    localparam logic [11:0] FieldWRst   = 12'd800;
    localparam logic [11:0] FieldHRst   = 12'd600;
    localparam logic [16:0] FrictionRst = 17'd58982;

    localparam int DivW            = 32;
    localparam int DivsrW          = 16;
    localparam int DivBitsPerStage = 2;
    localparam int DivStages       = DivW / DivBitsPerStage;

    localparam logic signed [ProdW-1:0] S32Max = 50'sd2147483647;
    localparam logic signed [ProdW-1:0] S32Min = -50'sd2147483648;
    localparam logic signed [ProdW-1:0] QOne   = 50'sd65536;
    localparam logic signed [ProdW-1:0] QMask  = 50'sd65535;

    typedef struct packed {
        logic signed [DataW-1:0] pos_x;
        logic signed [DataW-1:0] pos_y;
        logic signed [DataW-1:0] vel_x;
        logic signed [DataW-1:0] vel_y;
        logic [15:0]             body_mass;
        logic [7:0]              body_radius;
    } pebs_in_t;

    typedef struct packed {
        logic signed [DataW-1:0] new_pos_x;
        logic signed [DataW-1:0] new_pos_y;
        logic signed [DataW-1:0] new_vel_x;
        logic signed [DataW-1:0] new_vel_y;
        logic                    hit_x_wall;
        logic                    hit_y_wall;
    } pebs_out_t;

    typedef struct packed {
        logic signed [DataW-1:0] pos_x;
        logic signed [DataW-1:0] pos_y;
        logic signed [DataW-1:0] vel_x;
        logic signed [DataW-1:0] vel_y;
        logic                    mass_zero;
        logic [7:0]              body_radius;
    } pebs_side_t;

    typedef struct packed {
        logic signed [DataW-1:0] pos_x;
        logic signed [DataW-1:0] pos_y;
        logic                    hit_x;
        logic                    hit_y;
    } pebs_fside_t;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic scale;
    } pebs_fctl_t;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] v);
        if (v > S32Max) begin
            return 32'sh7fffffff;
        end else if (v < S32Min) begin
            return 32'sh80000000;
        end
        return v[DataW-1:0];
    endfunction

    function automatic logic signed [ProdW-1:0] sx(input logic signed [DataW-1:0] v);
        return ProdW'(v);
    endfunction

    // division by 2^16 rounded toward zero
    function automatic logic signed [ProdW-1:0] trunc_q16(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-1:0] biased;
        biased = p[ProdW-1] ? p + QMask : p;
        return biased >>> 16;
    endfunction

    function automatic logic signed [DataW-1:0] neg_sat(input logic signed [DataW-1:0] v);
        return sat32(-sx(v));
    endfunction

endpackage

// ----- rtl/core/particle_euler_bounce_step_top.sv -----
// channel | direction | handshake          | word
// s_      | in        | s_valid / s_ready  | pos, vel, mass, radius
// m_      | out       | m_valid / m_ready  | new pos, new vel, wall hits
// cfg_    | in        | cfg_wr_en          | register index and data
//
// one word per cycle sustained while m_ready stays high
// gravity divider pipelined in 16 stages (two quotient bits per stage)
// synchronous active-low reset clears all stage valids and loads register defaults
// every stage holds its word while the next is full; empty stages close up under stall
module particle_euler_bounce_step_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pebs_pkg::CfgIdxW-1:0]     cfg_wr_index,
    input  logic [pebs_pkg::CfgDataW-1:0]    cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pebs_pkg::pebs_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pebs_pkg::pebs_out_t              m_data
);
    import pebs_pkg::*;

    logic [15:0] time_step_reg;
    logic [23:0] gravity_reg;
    logic [11:0] field_w_reg;
    logic [11:0] field_h_reg;
    logic [16:0] friction_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TimeStepRst;
            gravity_reg   <= GravityRst;
            field_w_reg   <= FieldWRst;
            field_h_reg   <= FieldHRst;
            friction_reg  <= FrictionRst;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_TIME_STEP: time_step_reg <= cfg_wr_data[15:0];
                CFG_GRAVITY:   gravity_reg   <= cfg_wr_data[23:0];
                CFG_FIELD_W:   field_w_reg   <= cfg_wr_data[11:0];
                CFG_FIELD_H:   field_h_reg   <= cfg_wr_data[11:0];
                CFG_FRICTION:  friction_reg  <= cfg_wr_data[16:0];
                default: begin
                end
            endcase
        end
    end

    // stage 1: products
    logic                    s1_vld_reg;
    pebs_in_t                s1_in_reg;
    logic signed [48:0]      s1_prod_x_reg, s1_prod_y_reg;
    logic signed [48:0]      s1_prod_x_next, s1_prod_y_next;
    logic [39:0]             s1_grav_reg, s1_grav_next;

    // stage 2: position step, divider operands
    logic                    s2_vld_reg;
    pebs_side_t              s2_side_reg, s2_side_next;
    logic [DivW-1:0]         s2_dvd_reg;
    logic [DivsrW-1:0]       s2_dvs_reg;

    logic                    s1_rdy, s2_rdy, s3_rdy;
    logic                    div_in_ready, div_out_valid;
    logic [DivW-1:0]         div_quot;
    pebs_side_t              div_side;

    // stage 3: gravity add, wall tests, nudge
    logic                    s3_vld_reg;
    logic signed [DataW-1:0] s3_vx_reg, s3_vy_reg;
    logic signed [DataW-1:0] s3_vy_next;
    logic                    s3_hx_next, s3_hy_next;
    pebs_fside_t             s3_side_reg, s3_side_next;
    logic signed [ProdW-1:0] half_r, lim_x, lim_y;
    logic                    left_x, right_x, left_y, right_y;

    logic                    fx_in_ready, fx_out_valid, fy_in_ready;
    logic signed [DataW-1:0] fx_a, fx_b, fy_a, fy_b;
    pebs_fside_t             fx_side, fy_side;
    pebs_fctl_t              fx_ctl, fy_ctl;

    assign s1_rdy  = !s1_vld_reg || s2_rdy;
    assign s2_rdy  = !s2_vld_reg || div_in_ready;
    assign s3_rdy  = !s3_vld_reg || fx_in_ready;
    assign s_ready = s1_rdy;

    assign s1_prod_x_next = $signed({1'b0, time_step_reg}) * s_data.vel_x;
    assign s1_prod_y_next = $signed({1'b0, time_step_reg}) * s_data.vel_y;
    assign s1_grav_next   = {24'b0, time_step_reg} * {16'b0, gravity_reg};

    always_comb begin
        s2_side_next.pos_x       = sat32(sx(s1_in_reg.pos_x)
                                         + trunc_q16(ProdW'(s1_prod_x_reg)));
        s2_side_next.pos_y       = sat32(sx(s1_in_reg.pos_y)
                                         + trunc_q16(ProdW'(s1_prod_y_reg)));
        s2_side_next.vel_x       = s1_in_reg.vel_x;
        s2_side_next.vel_y       = s1_in_reg.vel_y;
        s2_side_next.mass_zero   = (s1_in_reg.body_mass == '0);
        s2_side_next.body_radius = s1_in_reg.body_radius;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            if (s1_rdy) begin
                s1_vld_reg <= s_valid;
            end
            if (s2_rdy) begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s3_rdy) begin
                s3_vld_reg <= div_out_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy && s_valid) begin
            s1_in_reg     <= s_data;
            s1_prod_x_reg <= s1_prod_x_next;
            s1_prod_y_reg <= s1_prod_y_next;
            s1_grav_reg   <= s1_grav_next;
        end
        if (s2_rdy && s1_vld_reg) begin
            s2_side_reg <= s2_side_next;
            // dt*g / (mass*256) == (dt*g >> 8) / mass
            s2_dvd_reg  <= s1_grav_reg[39:8];
            s2_dvs_reg  <= s1_in_reg.body_mass;
        end
        if (s3_rdy && div_out_valid) begin
            s3_vx_reg   <= div_side.vel_x;
            s3_vy_reg   <= s3_vy_next;
            s3_side_reg <= s3_side_next;
        end
    end

    pebs_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s2_vld_reg),
        .in_ready    (div_in_ready),
        .in_dividend (s2_dvd_reg),
        .in_divisor  (s2_dvs_reg),
        .in_side     (s2_side_reg),
        .out_valid   (div_out_valid),
        .out_ready   (s3_rdy),
        .out_quot    (div_quot),
        .out_side    (div_side)
    );

    always_comb begin
        half_r  = ProdW'({div_side.body_radius, 15'b0});
        lim_x   = ProdW'({field_w_reg, 16'b0}) - half_r;
        lim_y   = ProdW'({field_h_reg, 16'b0}) - half_r;
        left_x  = sx(div_side.pos_x) < half_r;
        right_x = sx(div_side.pos_x) > lim_x;
        left_y  = sx(div_side.pos_y) < half_r;
        right_y = sx(div_side.pos_y) > lim_y;

        s3_hx_next = left_x || right_x;
        s3_hy_next = left_y || right_y;

        s3_vy_next = div_side.mass_zero ? div_side.vel_y
                   : sat32(sx(div_side.vel_y) + $signed(ProdW'(div_quot)));

        // left and down win over right and up
        if (left_x) begin
            s3_side_next.pos_x = sat32(sx(div_side.pos_x) + QOne);
        end else if (right_x) begin
            s3_side_next.pos_x = sat32(sx(div_side.pos_x) - QOne);
        end else begin
            s3_side_next.pos_x = div_side.pos_x;
        end
        if (left_y) begin
            s3_side_next.pos_y = sat32(sx(div_side.pos_y) + QOne);
        end else if (right_y) begin
            s3_side_next.pos_y = sat32(sx(div_side.pos_y) - QOne);
        end else begin
            s3_side_next.pos_y = div_side.pos_y;
        end
        s3_side_next.hit_x = s3_hx_next;
        s3_side_next.hit_y = s3_hy_next;
    end

    // x hit first, then y hit
    always_comb begin
        fx_ctl.neg_a = s3_side_reg.hit_x;
        fx_ctl.neg_b = 1'b0;
        fx_ctl.scale = s3_side_reg.hit_x;
        fy_ctl.neg_a = 1'b0;
        fy_ctl.neg_b = fx_side.hit_y;
        fy_ctl.scale = fx_side.hit_y;
    end

    pebs_fric u_fric_x (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wall_friction (friction_reg),
        .in_valid      (s3_vld_reg),
        .in_ready      (fx_in_ready),
        .in_a          (s3_vx_reg),
        .in_b          (s3_vy_reg),
        .in_ctl        (fx_ctl),
        .in_side       (s3_side_reg),
        .out_valid     (fx_out_valid),
        .out_ready     (fy_in_ready),
        .out_a         (fx_a),
        .out_b         (fx_b),
        .out_side      (fx_side)
    );

    pebs_fric u_fric_y (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wall_friction (friction_reg),
        .in_valid      (fx_out_valid),
        .in_ready      (fy_in_ready),
        .in_a          (fx_a),
        .in_b          (fx_b),
        .in_ctl        (fy_ctl),
        .in_side       (fx_side),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_a         (fy_a),
        .out_b         (fy_b),
        .out_side      (fy_side)
    );

    always_comb begin
        m_data.new_pos_x  = fy_side.pos_x;
        m_data.new_pos_y  = fy_side.pos_y;
        m_data.new_vel_x  = fy_a;
        m_data.new_vel_y  = fy_b;
        m_data.hit_x_wall = fy_side.hit_x;
        m_data.hit_y_wall = fy_side.hit_y;
    end

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_vld_reg)
        else $error("accepted word missing from first stage");

    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_vld_reg && !s2_rdy |=> s1_vld_reg && $stable(s1_prod_x_reg)
                                  && $stable(s1_grav_reg))
        else $error("first stage changed while stalled");

    a_s3_hit_nudges: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_rdy && div_out_valid && !s3_hx_next |=> s3_side_reg.pos_x == $past(div_side.pos_x))
        else $error("x position moved without a wall hit");

endmodule

// ----- rtl/core/pebs_div.sv -----
module pebs_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pebs_pkg::DivW-1:0]       in_dividend,
    input  logic [pebs_pkg::DivsrW-1:0]     in_divisor,
    input  pebs_pkg::pebs_side_t            in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pebs_pkg::DivW-1:0]       out_quot,
    output pebs_pkg::pebs_side_t            out_side
);
    import pebs_pkg::*;

    localparam int Last = DivStages - 1;

    typedef struct packed {
        logic [DivsrW-1:0] rem;
        logic [DivW-1:0]   dq;
    } pebs_dstep_t;

    // restoring division, two quotient bits per stage
    function automatic pebs_dstep_t div_step(input logic [DivsrW-1:0] rem,
                                             input logic [DivW-1:0] dq,
                                             input logic [DivsrW-1:0] dvs);
        logic [DivsrW:0] r;
        logic [DivW-1:0] d;
        logic [DivsrW-1:0] rr;
        pebs_dstep_t res;
        rr = rem;
        d  = dq;
        for (int k = 0; k < DivBitsPerStage; k++) begin
            r = {rr, d[DivW-1]};
            d = {d[DivW-2:0], 1'b0};
            if (r >= {1'b0, dvs}) begin
                r    = r - {1'b0, dvs};
                d[0] = 1'b1;
            end
            rr = r[DivsrW-1:0];
        end
        res.rem = rr;
        res.dq  = d;
        return res;
    endfunction

    logic              vld_reg  [DivStages];
    logic [DivsrW-1:0] rem_reg  [DivStages];
    logic [DivW-1:0]   dq_reg   [DivStages];
    logic [DivsrW-1:0] dvs_reg  [DivStages];
    pebs_side_t        side_reg [DivStages];

    logic              rdy      [DivStages+1];
    logic              prv_vld  [DivStages];
    logic [DivsrW-1:0] prv_rem  [DivStages];
    logic [DivW-1:0]   prv_dq   [DivStages];
    logic [DivsrW-1:0] prv_dvs  [DivStages];
    pebs_side_t        prv_side [DivStages];
    pebs_dstep_t       step_next [DivStages];

    assign rdy[DivStages] = out_ready;

    for (genvar g = 0; g < DivStages; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign prv_vld[g]  = in_valid;
            assign prv_rem[g]  = '0;
            assign prv_dq[g]   = in_dividend;
            assign prv_dvs[g]  = in_divisor;
            assign prv_side[g] = in_side;
        end else begin : g_rest
            assign prv_vld[g]  = vld_reg[g-1];
            assign prv_rem[g]  = rem_reg[g-1];
            assign prv_dq[g]   = dq_reg[g-1];
            assign prv_dvs[g]  = dvs_reg[g-1];
            assign prv_side[g] = side_reg[g-1];
        end

        assign rdy[g]       = !vld_reg[g] || rdy[g+1];
        assign step_next[g] = div_step(prv_rem[g], prv_dq[g], prv_dvs[g]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                vld_reg[g] <= prv_vld[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[g] && prv_vld[g]) begin
                rem_reg[g]  <= step_next[g].rem;
                dq_reg[g]   <= step_next[g].dq;
                dvs_reg[g]  <= prv_dvs[g];
                side_reg[g] <= prv_side[g];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[Last];
    assign out_quot  = dq_reg[Last];
    assign out_side  = side_reg[Last];

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[Last] && dvs_reg[Last] != '0 |-> rem_reg[Last] < dvs_reg[Last])
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/core/pebs_fric.sv -----
module pebs_fric (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [16:0]                        wall_friction,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [pebs_pkg::DataW-1:0]  in_a,
    input  logic signed [pebs_pkg::DataW-1:0]  in_b,
    input  pebs_pkg::pebs_fctl_t               in_ctl,
    input  pebs_pkg::pebs_fside_t              in_side,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pebs_pkg::DataW-1:0]  out_a,
    output logic signed [pebs_pkg::DataW-1:0]  out_b,
    output pebs_pkg::pebs_fside_t              out_side
);
    import pebs_pkg::*;

    // stage 1: reflect the normal component
    logic                    f1_vld_reg;
    logic signed [DataW-1:0] f1_a_reg, f1_b_reg;
    logic signed [DataW-1:0] f1_a_next, f1_b_next;
    logic                    f1_scale_reg;
    pebs_fside_t             f1_side_reg;

    // stage 2: friction products
    logic                    f2_vld_reg;
    logic signed [DataW-1:0] f2_a_reg, f2_b_reg;
    logic signed [ProdW-1:0] f2_pa_reg, f2_pb_reg;
    logic signed [ProdW-1:0] f2_pa_next, f2_pb_next;
    logic                    f2_scale_reg;
    pebs_fside_t             f2_side_reg;

    // stage 3: rescale and pick
    logic                    f3_vld_reg;
    logic signed [DataW-1:0] f3_a_reg, f3_b_reg;
    logic signed [DataW-1:0] f3_a_next, f3_b_next;
    pebs_fside_t             f3_side_reg;

    logic f1_rdy, f2_rdy, f3_rdy;

    assign f3_rdy   = !f3_vld_reg || out_ready;
    assign f2_rdy   = !f2_vld_reg || f3_rdy;
    assign f1_rdy   = !f1_vld_reg || f2_rdy;
    assign in_ready = f1_rdy;

    assign f1_a_next  = in_ctl.neg_a ? neg_sat(in_a) : in_a;
    assign f1_b_next  = in_ctl.neg_b ? neg_sat(in_b) : in_b;
    assign f2_pa_next = f1_a_reg * $signed({1'b0, wall_friction});
    assign f2_pb_next = f1_b_reg * $signed({1'b0, wall_friction});
    assign f3_a_next  = f2_scale_reg ? sat32(trunc_q16(f2_pa_reg)) : f2_a_reg;
    assign f3_b_next  = f2_scale_reg ? sat32(trunc_q16(f2_pb_reg)) : f2_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end else begin
            if (f1_rdy) begin
                f1_vld_reg <= in_valid;
            end
            if (f2_rdy) begin
                f2_vld_reg <= f1_vld_reg;
            end
            if (f3_rdy) begin
                f3_vld_reg <= f2_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_rdy && in_valid) begin
            f1_a_reg     <= f1_a_next;
            f1_b_reg     <= f1_b_next;
            f1_scale_reg <= in_ctl.scale;
            f1_side_reg  <= in_side;
        end
        if (f2_rdy && f1_vld_reg) begin
            f2_a_reg     <= f1_a_reg;
            f2_b_reg     <= f1_b_reg;
            f2_pa_reg    <= f2_pa_next;
            f2_pb_reg    <= f2_pb_next;
            f2_scale_reg <= f1_scale_reg;
            f2_side_reg  <= f1_side_reg;
        end
        if (f3_rdy && f2_vld_reg) begin
            f3_a_reg    <= f3_a_next;
            f3_b_reg    <= f3_b_next;
            f3_side_reg <= f2_side_reg;
        end
    end

    assign out_valid = f3_vld_reg;
    assign out_a     = f3_a_reg;
    assign out_b     = f3_b_reg;
    assign out_side  = f3_side_reg;

endmodule
